// ===== design/adif_pkg.sv =====
// Package for the aging duplicate-id filter.
// Holds field widths, the stored entry layout and the controller/datapath bundles.
// Depends on nothing.
package adif_pkg;

    localparam int ADIF_DEPTH = 32;
    localparam int ADDR_W = 32;
    localparam int SEC_W = 32;
    localparam int USEC_W = 20;
    localparam int KIND_W = 4;
    localparam int STAMP_W = 32;
    localparam int LIMIT_W = 16;
    localparam logic [LIMIT_W-1:0] AGE_LIMIT_RESET = 16'd300;

    typedef struct packed {
        logic [ADDR_W-1:0]  address;
        logic [SEC_W-1:0]   seconds;
        logic [USEC_W-1:0]  microseconds;
        logic [KIND_W-1:0]  kind;
        logic [STAMP_W-1:0] stamp;
    } adif_entry_t;

    typedef struct packed {
        logic load_item;
        logic rd_head;
        logic drop_head;
        logic set_evict;
        logic init_pos;
        logic rd_search;
        logic dec_pos;
        logic rd_shift;
        logic wr_shift;
        logic wr_insert;
        logic set_dup;
        logic out_load;
    } adif_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic full;
        logic aged;
        logic pos_zero;
        logic id_gt;
        logic id_match;
        logic shift_done;
        logic out_free;
    } adif_stat_t;

endpackage

// ===== design/aging_duplicate_id_filter.sv =====
// Top level of the aging duplicate-id filter.
// Joins adif_controller and adif_datapath; depends on adif_pkg.
//
// Usage:
// The input channel (in_valid, in_stall) carries one request: a unique id
// (address, seconds, microseconds), a notice kind and the current time.
// The output channel (out_valid, out_stall) returns one result per request:
// is_duplicate and evicted_when_full. The configuration channel (cfg_valid,
// cfg_ready, cfg_data) writes the age limit in seconds; cfg_ready is always
// high. Writes are to be made by the user only while the block is idle; the
// block itself does not enforce this. One request is handled at a time. An
// accepted request first drops aged-out entries from the head, evicts the
// head when the ring is full, searches backward for a duplicate or its
// sorted place, moves the entries behind that place up and inserts it; a
// duplicate skips the moving and the insertion. The next request is taken in
// the cycle after the result is loaded. The entry memory is single-port with
// a registered read. The result sits in an output register, so a new request
// is taken while a stalled result waits; a further result waits in the
// controller until the register is free. Reset empties the ring and sets the
// age limit to 300.
module aging_duplicate_id_filter
    import adif_pkg::*;
#(
    parameter int DEPTH = ADIF_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [ADDR_W-1:0]   id_address,
    input  logic [SEC_W-1:0]    id_seconds,
    input  logic [USEC_W-1:0]   id_microseconds,
    input  logic [KIND_W-1:0]   notice_kind,
    input  logic [STAMP_W-1:0]  now_seconds,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                is_duplicate,
    output logic                evicted_when_full,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [LIMIT_W-1:0]  cfg_data
);

    adif_cmd_t  cmd;
    adif_stat_t stat;

    assign cfg_ready = 1'b1;

    adif_controller u_controller (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    adif_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .cfg_write         (cfg_valid && cfg_ready),
        .cfg_data          (cfg_data),
        .id_address        (id_address),
        .id_seconds        (id_seconds),
        .id_microseconds   (id_microseconds),
        .notice_kind       (notice_kind),
        .now_seconds       (now_seconds),
        .out_stall         (out_stall),
        .out_valid         (out_valid),
        .is_duplicate      (is_duplicate),
        .evicted_when_full (evicted_when_full)
    );

endmodule

// ===== design/adif_datapath.sv =====
// Datapath of the aging duplicate-id filter: entry memory, ring pointers,
// comparators, configuration register and output register.
// Depends on adif_pkg.
module adif_datapath
    import adif_pkg::*;
#(
    parameter int DEPTH = ADIF_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  adif_cmd_t           cmd,
    output adif_stat_t          stat,
    input  logic                cfg_write,
    input  logic [LIMIT_W-1:0]  cfg_data,
    input  logic [ADDR_W-1:0]   id_address,
    input  logic [SEC_W-1:0]    id_seconds,
    input  logic [USEC_W-1:0]   id_microseconds,
    input  logic [KIND_W-1:0]   notice_kind,
    input  logic [STAMP_W-1:0]  now_seconds,
    input  logic                out_stall,
    output logic                out_valid,
    output logic                is_duplicate,
    output logic                evicted_when_full
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W:0] DEPTH_SUM = (CNT_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    adif_entry_t mem [DEPTH];
    adif_entry_t rd_data_reg;
    adif_entry_t item_reg;

    logic [IDX_W-1:0]   head_reg;
    logic [IDX_W-1:0]   head_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   pos_reg;
    logic [CNT_W-1:0]   shift_reg;
    logic [LIMIT_W-1:0] age_limit_reg;
    logic               dup_reg;
    logic               evict_reg;
    logic               out_valid_reg;
    logic               out_dup_reg;
    logic               out_evict_reg;

    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    adif_entry_t        wr_data;
    logic               rd_en;
    logic               wr_en;
    logic [STAMP_W-1:0] age;
    logic [ADDR_W+SEC_W+USEC_W-1:0] new_id;
    logic [ADDR_W+SEC_W+USEC_W-1:0] old_id;

    function automatic logic [IDX_W-1:0] slot_of(
        input logic [IDX_W-1:0] head,
        input logic [CNT_W-1:0] offset
    );
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - IDX_W){1'b0}}, head} + {1'b0, offset};
        if (sum >= DEPTH_SUM)
        begin
            sum = sum - DEPTH_SUM;
        end
        return sum[IDX_W-1:0];
    endfunction

    always_comb
    begin
        head_next = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
        count_next = count_reg;
        if (cmd.drop_head)
        begin
            count_next = count_reg - 1'b1;
        end
        else if (cmd.wr_insert)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_comb
    begin
        rd_en = cmd.rd_head | cmd.rd_search | cmd.rd_shift;
        wr_en = cmd.wr_shift | cmd.wr_insert;
        if (cmd.rd_search)
        begin
            rd_addr = slot_of(head_reg, pos_reg - 1'b1);
        end
        else if (cmd.rd_shift)
        begin
            rd_addr = slot_of(head_reg, shift_reg - 1'b1);
        end
        else
        begin
            rd_addr = head_reg;
        end
        if (cmd.wr_shift)
        begin
            wr_addr = slot_of(head_reg, shift_reg);
            wr_data = rd_data_reg;
        end
        else
        begin
            wr_addr = slot_of(head_reg, pos_reg);
            wr_data = item_reg;
        end
    end

    always_comb
    begin
        age = item_reg.stamp - rd_data_reg.stamp;
        new_id = {item_reg.address, item_reg.seconds, item_reg.microseconds};
        old_id = {rd_data_reg.address, rd_data_reg.seconds, rd_data_reg.microseconds};
        stat.count_zero = (count_reg == '0);
        stat.full = (count_reg == DEPTH_CNT);
        stat.aged = (age > {{(STAMP_W - LIMIT_W){1'b0}}, age_limit_reg});
        stat.pos_zero = (pos_reg == '0);
        stat.id_gt = (new_id > old_id);
        stat.id_match = (new_id == old_id) && (item_reg.kind == rd_data_reg.kind);
        stat.shift_done = (shift_reg == pos_reg);
        stat.out_free = !out_valid_reg || !out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            count_reg <= '0;
            age_limit_reg <= AGE_LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.drop_head)
            begin
                head_reg <= head_next;
            end
            count_reg <= count_next;
            if (cfg_write)
            begin
                age_limit_reg <= cfg_data;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= '{address: id_address, seconds: id_seconds,
                          microseconds: id_microseconds, kind: notice_kind,
                          stamp: now_seconds};
            dup_reg <= 1'b0;
            evict_reg <= 1'b0;
        end
        if (cmd.set_evict)
        begin
            evict_reg <= 1'b1;
        end
        if (cmd.set_dup)
        begin
            dup_reg <= 1'b1;
        end
        if (cmd.init_pos)
        begin
            pos_reg <= count_reg;
            shift_reg <= count_reg;
        end
        else
        begin
            if (cmd.dec_pos)
            begin
                pos_reg <= pos_reg - 1'b1;
            end
            if (cmd.wr_shift)
            begin
                shift_reg <= shift_reg - 1'b1;
            end
        end
        if (cmd.out_load)
        begin
            out_dup_reg <= dup_reg;
            out_evict_reg <= evict_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign out_valid = out_valid_reg;
    assign is_duplicate = out_dup_reg;
    assign evicted_when_full = out_evict_reg;

endmodule

// ===== design/adif_controller.sv =====
// Controller of the aging duplicate-id filter: sequences aging, eviction,
// backward search, shifting insertion and the result hand-over.
// Depends on adif_pkg.
module adif_controller
    import adif_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  adif_stat_t stat,
    output adif_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AGE_RD,
        ST_AGE_CHK,
        ST_FULL_CHK,
        ST_PREP,
        ST_SRCH_RD,
        ST_SRCH_CHK,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_INSERT,
        ST_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;

    always_comb
    begin
        state_next = state_reg;
        busy_next = busy_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    busy_next = 1'b1;
                    state_next = ST_AGE_RD;
                end
            end
            ST_AGE_RD:
            begin
                if (stat.count_zero)
                begin
                    state_next = ST_FULL_CHK;
                end
                else
                begin
                    cmd.rd_head = 1'b1;
                    state_next = ST_AGE_CHK;
                end
            end
            ST_AGE_CHK:
            begin
                if (stat.aged)
                begin
                    cmd.drop_head = 1'b1;
                    state_next = ST_AGE_RD;
                end
                else
                begin
                    state_next = ST_FULL_CHK;
                end
            end
            ST_FULL_CHK:
            begin
                if (stat.full)
                begin
                    cmd.drop_head = 1'b1;
                    cmd.set_evict = 1'b1;
                end
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.init_pos = 1'b1;
                state_next = ST_SRCH_RD;
            end
            ST_SRCH_RD:
            begin
                if (stat.pos_zero)
                begin
                    state_next = ST_SHIFT_RD;
                end
                else
                begin
                    cmd.rd_search = 1'b1;
                    state_next = ST_SRCH_CHK;
                end
            end
            ST_SRCH_CHK:
            begin
                if (stat.id_match)
                begin
                    cmd.set_dup = 1'b1;
                    state_next = ST_RESULT;
                end
                else if (stat.id_gt)
                begin
                    state_next = ST_SHIFT_RD;
                end
                else
                begin
                    cmd.dec_pos = 1'b1;
                    state_next = ST_SRCH_RD;
                end
            end
            ST_SHIFT_RD:
            begin
                if (stat.shift_done)
                begin
                    state_next = ST_INSERT;
                end
                else
                begin
                    cmd.rd_shift = 1'b1;
                    state_next = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR:
            begin
                cmd.wr_shift = 1'b1;
                state_next = ST_SHIFT_RD;
            end
            ST_INSERT:
            begin
                cmd.wr_insert = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    busy_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                busy_next = 1'b0;
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg <= busy_next;
        end
    end

    assign in_stall = busy_reg;

endmodule

// ===== design/adif_checker.sv =====
// Port-level checks for the aging duplicate-id filter, bound to the top level.
// Depends on aging_duplicate_id_filter being compiled first.
module adif_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic is_duplicate,
    input logic evicted_when_full
);

    // An accepted request keeps the block busy for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted but input not stalled afterwards");

    // The block only becomes ready again once it has produced a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_stall) |-> out_valid)
        else $error("block became ready without presenting a result");

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            out_valid && $stable(is_duplicate) && $stable(evicted_when_full))
        else $error("stalled result changed or was withdrawn");

endmodule

bind aging_duplicate_id_filter adif_checker u_adif_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .is_duplicate      (is_duplicate),
    .evicted_when_full (evicted_when_full)
);

// ===== test/testbench.sv =====
// Self-checking testbench for the aging duplicate-id filter.
// It predicts every result from its own copy of the sorted entry ring and checks it
// field by field. It depends on adif_pkg and aging_duplicate_id_filter.
`timescale 1ns / 100ps

module testbench;
    import adif_pkg::*;

    localparam int RING_IDX_W = $clog2(ADIF_DEPTH);

    typedef struct packed {
        logic [ADDR_W-1:0]  address;
        logic [SEC_W-1:0]   seconds;
        logic [USEC_W-1:0]  microseconds;
        logic [KIND_W-1:0]  kind;
        logic [STAMP_W-1:0] now;
    } request_t;

    typedef struct packed {
        logic duplicate;
        logic evicted;
    } verdict_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [ADDR_W-1:0]  id_address = '0;
    logic [SEC_W-1:0]   id_seconds = '0;
    logic [USEC_W-1:0]  id_microseconds = '0;
    logic [KIND_W-1:0]  notice_kind = '0;
    logic [STAMP_W-1:0] now_seconds = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               is_duplicate;
    logic               evicted_when_full;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_data = '0;

    adif_entry_t             ring [ADIF_DEPTH];
    logic [RING_IDX_W-1:0]   ring_head = '0;
    int unsigned             ring_count = 0;
    logic [LIMIT_W-1:0]      age_limit = AGE_LIMIT_RESET;

    verdict_t           verdicts_due [$];
    verdict_t           oldest_verdict;
    int unsigned        mismatch_count = 0;
    int unsigned        send_idle_pct = 0;
    int unsigned        recv_stall_pct = 0;
    int unsigned        hold_off_left = 0;
    request_t           recent [$];
    logic [STAMP_W-1:0] wall_clock = '0;

    aging_duplicate_id_filter DUT
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .id_address        (id_address),
        .id_seconds        (id_seconds),
        .id_microseconds   (id_microseconds),
        .notice_kind       (notice_kind),
        .now_seconds       (now_seconds),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .is_duplicate      (is_duplicate),
        .evicted_when_full (evicted_when_full),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("aging_duplicate_id_filter verification failed");
        $finish;
    end

    function automatic logic [RING_IDX_W-1:0] ring_slot(input int unsigned offset);
        return RING_IDX_W'((ring_head + offset) % ADIF_DEPTH);
    endfunction

    function automatic verdict_t screen_request(input request_t r);
        verdict_t              v;
        int unsigned           pos;
        int unsigned           j;
        logic [RING_IDX_W-1:0] slot;
        logic [STAMP_W-1:0]    age;
        adif_entry_t           fresh;
        v = '0;
        while (ring_count > 0)
        begin
            age = r.now - ring[ring_head].stamp;
            if (age <= {16'd0, age_limit})
                break;
            ring_head = ring_slot(1);
            ring_count--;
        end
        if (ring_count >= ADIF_DEPTH)
        begin
            ring_head = ring_slot(1);
            ring_count--;
            v.evicted = 1'b1;
        end
        pos = ring_count;
        while (pos > 0)
        begin
            slot = ring_slot(pos - 1);
            if ({r.address, r.seconds, r.microseconds} ==
                {ring[slot].address, ring[slot].seconds, ring[slot].microseconds} &&
                r.kind == ring[slot].kind)
            begin
                v.duplicate = 1'b1;
                return v;
            end
            if ({r.address, r.seconds, r.microseconds} >
                {ring[slot].address, ring[slot].seconds, ring[slot].microseconds})
                break;
            pos--;
        end
        for (j = ring_count; j > pos; j--)
            ring[ring_slot(j)] = ring[ring_slot(j - 1)];
        fresh.address = r.address;
        fresh.seconds = r.seconds;
        fresh.microseconds = r.microseconds;
        fresh.kind = r.kind;
        fresh.stamp = r.now;
        ring[ring_slot(pos)] = fresh;
        ring_count++;
        return v;
    endfunction

    function automatic request_t make_request(input logic [ADDR_W-1:0] a,
                                              input logic [SEC_W-1:0] s,
                                              input logic [USEC_W-1:0] us,
                                              input logic [KIND_W-1:0] k,
                                              input logic [STAMP_W-1:0] t);
        request_t r;
        r.address = a;
        r.seconds = s;
        r.microseconds = us;
        r.kind = k;
        r.now = t;
        return r;
    endfunction

    // Most requests reuse a recent id or draw from a narrow range, so that duplicates,
    // equal ids of another kind and sorted insertion in the middle occur often.
    function automatic request_t random_request();
        request_t    r;
        int unsigned pick;
        pick = $urandom_range(99);
        if (recent.size() > 0 && pick < 35)
        begin
            r = recent[$urandom_range(recent.size() - 1)];
            if ($urandom_range(3) == 0)
                r.kind = KIND_W'($urandom_range(15));
        end
        else
        begin
            r.address = ($urandom_range(3) == 0) ? $urandom : $urandom_range(7);
            r.seconds = ($urandom_range(3) == 0) ? $urandom : $urandom_range(7);
            r.microseconds = USEC_W'(($urandom_range(3) == 0) ? $urandom_range(2**20 - 1)
                                                               : $urandom_range(5));
            r.kind = KIND_W'($urandom_range(15));
        end
        pick = $urandom_range(99);
        if (pick < 2)
            wall_clock = $urandom;
        else if (pick < 4)
            wall_clock = wall_clock - $urandom_range(1000);
        else if (pick < 8)
            wall_clock = wall_clock + $urandom_range(400);
        else
            wall_clock = wall_clock + $urandom_range(2);
        r.now = wall_clock;
        recent.push_back(r);
        if (recent.size() > 48)
            void'(recent.pop_front());
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (hold_off_left > 0)
        begin
            out_stall <= 1'b1;
            hold_off_left <= hold_off_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (verdicts_due.size() == 0)
            begin
                $display("%0t: unexpected result, is_duplicate %0b evicted_when_full %0b",
                         $time, is_duplicate, evicted_when_full);
                mismatch_count++;
            end
            else
            begin
                oldest_verdict = verdicts_due.pop_front();
                if (is_duplicate !== oldest_verdict.duplicate)
                begin
                    $display("%0t: is_duplicate expected %0b, got %0b",
                             $time, oldest_verdict.duplicate, is_duplicate);
                    mismatch_count++;
                end
                if (evicted_when_full !== oldest_verdict.evicted)
                begin
                    $display("%0t: evicted_when_full expected %0b, got %0b",
                             $time, oldest_verdict.evicted, evicted_when_full);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic send_request(input request_t r);
        int unsigned gap;
        in_valid <= 1'b1;
        id_address <= r.address;
        id_seconds <= r.seconds;
        id_microseconds <= r.microseconds;
        notice_kind <= r.kind;
        now_seconds <= r.now;
        do
            @(posedge clk);
        while (in_stall);
        verdicts_due.push_back(screen_request(r));
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results(input int unsigned settle);
        in_valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_age_limit(input logic [LIMIT_W-1:0] limit);
        drain_results(8);
        cfg_valid <= 1'b1;
        cfg_data <= limit;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        age_limit = limit;
    endtask

    task automatic test_field_extremes;
        send_request(make_request('0, '0, '0, 4'd0, 32'd0));
        send_request(make_request('0, '0, '0, 4'd0, 32'd0));
        send_request(make_request('1, '1, '1, 4'd15, 32'd5));
        send_request(make_request('1, '1, '1, 4'd14, 32'd5));
        send_request(make_request('1, '1, '1, 4'd15, 32'd6));
        send_request(make_request('1, '1, '1, 4'd14, 32'd6));
        send_request(make_request(32'd1, 32'd1, 20'd999999, 4'd3, 32'd7));
        send_request(make_request(32'd1, 32'd1, 20'd1000000, 4'd3, 32'd7));
        send_request(make_request(32'd1, 32'd1, 20'd1000000, 4'd3, 32'hFFFFFFFF));
        send_request(make_request(32'd1, 32'd1, 20'd1000000, 4'd3, 32'd2));
    endtask

    task automatic test_notice_kinds;
        send_request(make_request(32'd50, 32'd8, 20'd8, 4'd1, 32'd10));
        send_request(make_request(32'd50, 32'd8, 20'd8, 4'd2, 32'd10));
        send_request(make_request(32'd50, 32'd8, 20'd8, 4'd9, 32'd10));
        send_request(make_request(32'd50, 32'd8, 20'd8, 4'd1, 32'd10));
        send_request(make_request(32'd50, 32'd8, 20'd7, 4'd1, 32'd10));
        send_request(make_request(32'd50, 32'd8, 20'd9, 4'd2, 32'd10));
    endtask

    // Aging looks only at the head entry, which holds the smallest id, and drops head entries while they are aged out.
    task automatic test_head_aging;
        write_age_limit(16'd10);
        send_request(make_request(32'd5, '0, '0, 4'd4, 32'd100));
        send_request(make_request(32'd9, '0, '0, 4'd4, 32'd100));
        send_request(make_request(32'd2, '0, '0, 4'd4, 32'd108));
        send_request(make_request(32'd5, '0, '0, 4'd4, 32'd112));
        send_request(make_request(32'd9, '0, '0, 4'd4, 32'd120));
        write_age_limit(16'd0);
        send_request(make_request(32'd9, '0, '0, 4'd4, 32'd120));
        send_request(make_request(32'd9, '0, '0, 4'd4, 32'd121));
    endtask

    task automatic test_table_overflow;
        request_t    first;
        request_t    r;
        int unsigned i;
        write_age_limit(16'hFFFF);
        first = make_request($urandom, $urandom, USEC_W'($urandom_range(999999)),
                             KIND_W'($urandom_range(15)), 32'd7000);
        r = first;
        send_request(first);
        for (i = 0; i < 34; i++)
        begin
            r = make_request($urandom, $urandom, USEC_W'($urandom_range(999999)),
                             KIND_W'($urandom_range(15)), 32'd7000);
            send_request(r);
        end
        send_request(r);
        send_request(first);
    endtask

    task automatic test_output_hold_off;
        int unsigned i;
        drain_results(8);
        set_idling(0, 0);
        hold_off_left <= 400;
        for (i = 0; i < 12; i++)
            send_request(make_request($urandom_range(3), $urandom_range(3),
                                      USEC_W'($urandom_range(3)),
                                      KIND_W'($urandom_range(15)), 32'd7000));
        drain_results(8);
    endtask

    task automatic test_random_traffic;
        logic [LIMIT_W-1:0] limits [8];
        int unsigned        phase;
        limits = '{16'd300, 16'd0, 16'd65535, 16'd40, 16'd5, 16'd1000, 16'd2, 16'd120};
        wall_clock = $urandom;
        recent.delete();
        for (phase = 0; phase < 8; phase++)
        begin
            write_age_limit(limits[phase]);
            case (phase % 4)
                0: set_idling(0, 0);
                1: set_idling(80, 0);
                2: set_idling(0, 80);
                default: set_idling(10, 10);
            endcase
            repeat (130) send_request(random_request());
        end
        set_idling(0, 0);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_field_extremes();
        test_notice_kinds();
        test_head_aging();
        test_table_overflow();
        test_output_hold_off();
        test_random_traffic();
        drain_results(150);
        if (mismatch_count == 0)
            $display("aging_duplicate_id_filter verification clean");
        else
            $display("aging_duplicate_id_filter verification failed");
        $finish;
    end

endmodule
